// ===== rtl/gbei_pkg.sv =====
// Shared constants and register codes for the grain boundary energy init unit.
// No dependencies; imported by the top level.
`default_nettype none

package gbei_pkg;

  // Parameter defaults
  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned DEF_ID_BITS  = 16;

  // Fixed field and register widths
  localparam int unsigned GRAIN_W    = 16;
  localparam int unsigned ENERGY_W   = 8;
  localparam int unsigned COLS_W     = 11;
  localparam int unsigned ROWS_W     = 16;
  localparam int unsigned ROW_POS_W  = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_DATA_W   = 16;
  localparam int unsigned M_DATA_W   = 16;

  // Saturation point of the arrival row counter
  localparam logic [ROW_POS_W-1:0] ROW_POS_MAX = '1;

  // Register reset values
  localparam logic [COLS_W-1:0]   COLS_RST      = 11'd1024;
  localparam logic [ROWS_W-1:0]   ROWS_RST      = 16'd1024;
  localparam logic [ENERGY_W-1:0] BOUNDARY_RST  = 8'd1;
  localparam logic [ENERGY_W-1:0] INTERIOR_RST  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS     = 2'd0,
    REG_ROWS     = 2'd1,
    REG_BOUNDARY = 2'd2,
    REG_INTERIOR = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/grain_boundary_energy_init_unit.sv =====
// Grain boundary energy initialiser: line stores, 3x3 window, clipped Moore test.
// Depends on gbei_pkg for widths, defaults and register codes.
// Path: the transaction that completes a result is registered in stage one, then the result in the output register.
// Throughput: one cell per cycle while the output register is not held by m_tready.
// Each result lags its cell by one row plus one cell; cols+1 drain ticks flush a frame.
// Reset (rst, synchronous): registers back to defaults, position to top-left, then a
// clearing pass over all MAX_COLS entries zeroes both line stores; s_tready stays low meanwhile.
`default_nettype none

module grain_boundary_energy_init_unit #(
  parameter int unsigned MAX_COLS = gbei_pkg::DEF_MAX_COLS,
  parameter int unsigned ID_BITS  = gbei_pkg::DEF_ID_BITS
) (
  input  wire                                clk,
  input  wire                                rst,
  // input cells
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [gbei_pkg::S_DATA_W-1:0]      s_tdata,   // [15:0] grain_id
  input  wire                                s_tuser,   // [0] op (1 = drain tick)
  // results
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [gbei_pkg::M_DATA_W-1:0]      m_tdata,   // [7:0] energy, [8] on_boundary, rest 0
  output logic                               m_tlast,   // last_of_frame
  // configuration writes
  input  wire                                cfg_wr_en,
  input  wire  [gbei_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [gbei_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import gbei_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COLS_W-1:0]   cols_in_use;
  logic [ROWS_W-1:0]   rows_in_use;
  logic [ENERGY_W-1:0] boundary_energy;
  logic [ENERGY_W-1:0] interior_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use     <= COLS_RST;
      rows_in_use     <= ROWS_RST;
      boundary_energy <= BOUNDARY_RST;
      interior_energy <= INTERIOR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLS:     cols_in_use     <= cfg_wdata[COLS_W-1:0];
        REG_ROWS:     rows_in_use     <= cfg_wdata[ROWS_W-1:0];
        REG_BOUNDARY: boundary_energy <= cfg_wdata[ENERGY_W-1:0];
        REG_INTERIOR: interior_energy <= cfg_wdata[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: width clamped to [2, MAX_COLS], height at least 2
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;

  always_comb begin
    if (cols_in_use < COLS_W'(2))            cols_eff = COLS_W'(2);
    else if (32'(cols_in_use) > MAX_COLS)    cols_eff = COLS_W'(MAX_COLS);
    else                                     cols_eff = cols_in_use;
    rows_eff = (rows_in_use < ROWS_W'(2)) ? ROWS_W'(2) : rows_in_use;
  end

  // ---------------------------------------------------------------------------
  // Front end: arrival position and all positional decisions, taken at accept
  // ---------------------------------------------------------------------------
  logic [AW-1:0]        arrive_col;
  logic [ROW_POS_W-1:0] arrive_row;

  logic [ROW_POS_W-1:0] rows_ext, rows_m1, rr, row_inc;
  logic [COLS_W-1:0]    cols_m1, rc;
  logic                 draining, is_drain, has_result, last, col_wrap;
  logic [2:0]           row_ok, col_ok;
  logic [8:0]           nb_ok;
  logic [ID_BITS-1:0]   x_in;
  logic [AW-1:0]        col_next;
  logic [ROW_POS_W-1:0] row_next;

  always_comb begin
    rows_ext = {1'b0, rows_eff};
    rows_m1  = rows_ext - ROW_POS_W'(1);
    cols_m1  = cols_eff - COLS_W'(1);
    draining = arrive_row >= rows_ext;
    is_drain = s_tuser;
    x_in     = draining ? '0 : ID_BITS'(s_tdata);

    // Cell being resolved sits one row plus one cell behind the arrival
    if (arrive_col != '0) begin
      has_result = arrive_row != '0;
      rr         = arrive_row - ROW_POS_W'(1);
      rc         = COLS_W'(arrive_col) - COLS_W'(1);
    end else begin
      has_result = arrive_row >= ROW_POS_W'(2);
      rr         = arrive_row - ROW_POS_W'(2);
      rc         = cols_m1;
    end

    last = (rr > rows_m1) || ((rr == rows_m1) && (rc >= cols_m1));

    // Clipping of the neighbourhood at the lattice border
    row_ok[0] = (rr != '0) && (rr <= rows_ext);
    row_ok[1] = rr < rows_ext;
    row_ok[2] = rr < rows_m1;
    col_ok[0] = (rc != '0) && (rc <= cols_eff);
    col_ok[1] = rc < cols_eff;
    col_ok[2] = rc < cols_m1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nb_ok[r*3+c] = row_ok[r] & col_ok[c];
      end
    end
    nb_ok[4] = 1'b0;

    row_inc  = (arrive_row != ROW_POS_MAX) ? arrive_row + ROW_POS_W'(1) : arrive_row;
    col_wrap = (12'(arrive_col) + 12'd1) >= 12'(cols_eff);
    if (has_result && last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_wrap) begin
      col_next = '0;
      row_next = row_inc;
    end else begin
      col_next = arrive_col + AW'(1);
      row_next = arrive_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic          clr_busy;
  logic [AW-1:0] clr_cnt;

  logic               s1_valid, s1_has_result, s1_last, s1_byp;
  logic [AW-1:0]      s1_col;
  logic [ID_BITS-1:0] s1_x, byp_top, byp_mid;
  logic [8:0]         s1_nb_ok;

  logic s1_adv, accept, take;

  // A drain tick while cells are still due is taken and dropped
  assign s1_adv   = s1_valid && (!s1_has_result || !m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && !(is_drain && !draining);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy   <= 1'b1;
      clr_cnt    <= '0;
      arrive_col <= '0;
      arrive_row <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (32'(clr_cnt) == MAX_COLS - 1) clr_busy <= 1'b0;
      end
      if (take) begin
        arrive_col <= col_next;
        arrive_row <= row_next;
        s1_valid   <= 1'b1;
      end else if (s1_adv) begin
        s1_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col        <= arrive_col;
      s1_x          <= x_in;
      s1_has_result <= has_result;
      s1_last       <= last;
      s1_nb_ok      <= nb_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read at accept, written when the cell leaves stage one
  // ---------------------------------------------------------------------------
  logic [ID_BITS-1:0] upper_line  [MAX_COLS];
  logic [ID_BITS-1:0] middle_line [MAX_COLS];
  logic [ID_BITS-1:0] rd_top, rd_mid, top_eff, mid_eff;

  // Same column read and written on one edge: forward the data being written
  assign top_eff = s1_byp ? byp_top : rd_top;
  assign mid_eff = s1_byp ? byp_mid : rd_mid;

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      upper_line[clr_cnt]  <= '0;
      middle_line[clr_cnt] <= '0;
    end else if (s1_adv) begin
      upper_line[s1_col]   <= mid_eff;
      middle_line[s1_col]  <= s1_x;
    end
    if (take) begin
      rd_top  <= upper_line[arrive_col];
      rd_mid  <= middle_line[arrive_col];
      s1_byp  <= s1_adv && (s1_col == arrive_col);
      byp_top <= mid_eff;
      byp_mid <= s1_x;
    end
  end

  // ---------------------------------------------------------------------------
  // 3x3 window and boundary test
  // ---------------------------------------------------------------------------
  logic [ID_BITS-1:0] win      [9];
  logic [ID_BITS-1:0] win_next [9];
  logic               boundary;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3+0] = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = top_eff;
    win_next[5] = mid_eff;
    win_next[8] = s1_x;
    boundary = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (s1_nb_ok[k] && (win_next[k] != win_next[4])) boundary = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < 9; k++) win[k] <= win_next[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [ENERGY_W-1:0] out_energy;
  logic                out_boundary;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      out_energy   <= boundary ? boundary_energy : interior_energy;
      out_boundary <= boundary;
      m_tlast      <= s1_last;
    end
  end

  assign m_tdata = {(M_DATA_W - ENERGY_W - 1)'(0), out_boundary, out_energy};

endmodule

`default_nettype wire

// ===== verif/tb_grain_boundary_energy_init_unit.sv =====
// Self-checking testbench for grain_boundary_energy_init_unit: streams raster frames of grain ids,
// works out the boundary/interior energy of every cell in-house and checks results in order.
// Depends on gbei_pkg and the unit's RTL only.

module tb_grain_boundary_energy_init_unit;
  import gbei_pkg::*;

  localparam int MAX_COLS         = DEF_MAX_COLS;
  localparam int WATCHDOG_LIMIT   = 6000;  // clearing pass + long hold, several times over
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 4;     // output register latency plus margin
  localparam int RANDOM_CELLS     = 700;
  localparam int NO_IDLE_TAIL     = 300;

  // tuser op codes
  localparam bit OP_CELL  = 1'b0;
  localparam bit OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                on_boundary;
    logic                last_of_frame;
  } cell_energy_t;

  // DUT connections
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  wire                   s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;    // [15:0] grain_id
  logic                  s_tuser   = OP_CELL; // [0] op
  wire                   m_tvalid;
  logic                  m_tready  = 1'b0;
  wire  [M_DATA_W-1:0]   m_tdata;           // [7:0] energy, [8] on_boundary, rest 0
  wire                   m_tlast;
  logic                  cfg_wr_en = 1'b0;
  cfg_reg_t              cfg_index = REG_COLS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // In-house copy of the lattice scanner
  logic [GRAIN_W-1:0]  upper_ids  [MAX_COLS];
  logic [GRAIN_W-1:0]  middle_ids [MAX_COLS];
  logic [GRAIN_W-1:0]  window     [9];
  int                  arrive_col;
  int                  arrive_row;
  logic [COLS_W-1:0]   width_reg;
  logic [ROWS_W-1:0]   height_reg;
  logic [ENERGY_W-1:0] boundary_e;
  logic [ENERGY_W-1:0] interior_e;

  cell_energy_t pending_energies [$];
  cell_energy_t want;
  int           cells_taken   = 0;   // transactions that moved the scanner
  int           errors        = 0;
  int           idle_cycles   = 0;
  bit           allow_idle    = 1'b1;
  bit           long_hold_req = 1'b0;

  grain_boundary_energy_init_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Effective lattice sizes: width clamped to [2, MAX_COLS], height floored at 2
  function automatic int lattice_cols();
    int c;
    c = int'(width_reg);
    if (c < 2) c = 2;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int lattice_rows();
    int r;
    r = int'(height_reg);
    if (r < 2) r = 2;
    return r;
  endfunction

  // One accepted transaction: shift the line stores and window, resolve the cell one row
  // plus one cell behind the arrival, queue its energy if there is one.
  function automatic void resolve_cell(bit op, logic [GRAIN_W-1:0] gid);
    int                 cols;
    int                 rows;
    int                 col;
    int                 rr;
    int                 rc;
    int                 nr;
    int                 nc;
    bit                 draining;
    bit                 boundary;
    bit                 last;
    logic [GRAIN_W-1:0] x;
    logic [GRAIN_W-1:0] top;
    logic [GRAIN_W-1:0] mid;
    cell_energy_t       res;
    cols     = lattice_cols();
    rows     = lattice_rows();
    draining = arrive_row >= rows;
    // drain tick while cells are still due: no effect at all
    if (op == OP_DRAIN && !draining) return;
    cells_taken++;
    // during the drain a cell's id is discarded
    x   = draining ? '0 : gid;
    col = arrive_col % MAX_COLS;
    top = upper_ids[col];
    mid = middle_ids[col];
    upper_ids[col]  = mid;
    middle_ids[col] = x;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = x;
    if (arrive_col >= 1) begin
      rr = arrive_row - 1;
      rc = arrive_col - 1;
    end else begin
      rr = arrive_row - 2;
      rc = cols - 1;
    end
    if (arrive_col + 1 >= cols) begin
      arrive_col = 0;
      if (arrive_row < 'h1FFFF) arrive_row++;
    end else begin
      arrive_col++;
    end
    // startup of a frame: nothing resolved yet
    if (rr < 0) return;
    boundary = 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = rr + dr;
        nc = rc + dc;
        if (dr == 0 && dc == 0) continue;
        // neighbourhood clipped at the lattice border
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        if (window[(1+dr)*3 + 1 + dc] != window[4]) boundary = 1'b1;
      end
    end
    // a shrunk lattice can leave the resolved position past the final cell
    last = (rr > rows - 1) || (rr == rows - 1 && rc >= cols - 1);
    res.energy        = boundary ? boundary_e : interior_e;
    res.on_boundary   = boundary;
    res.last_of_frame = last;
    pending_energies.push_back(res);
    if (last) begin
      arrive_col = 0;
      arrive_row = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Register write; only called once the unit is idle
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_COLS:     width_reg  = val[COLS_W-1:0];
      REG_ROWS:     height_reg = val[ROWS_W-1:0];
      REG_BOUNDARY: boundary_e = val[ENERGY_W-1:0];
      REG_INTERIOR: interior_e = val[ENERGY_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one item, optionally after a random gap, and hold until the transaction completes
  task automatic send_cell(bit op, logic [GRAIN_W-1:0] gid);
    int gap;
    if (allow_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= gid;
    do @(posedge clk); while (!s_tready);
    resolve_cell(op, gid);
  endtask

  // Sender pauses until every expected result is in, then lets the pipeline settle
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_energies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Complete the current frame: remaining cells, then drain ticks until the frame's last result.
  // Some drain slots carry a cell instead, which must act as a tick.
  task automatic finish_frame(int noise_pct);
    while (arrive_col != 0 || arrive_row != 0) begin
      if (arrive_row < lattice_rows()) send_cell(OP_CELL, GRAIN_W'($urandom));
      else if ($urandom_range(0, 99) < noise_pct * 5) send_cell(OP_CELL, GRAIN_W'($urandom));
      else send_cell(OP_DRAIN, GRAIN_W'($urandom));
    end
  endtask

  // Whole frame of blocky grains from a small random palette, with some scattered cells
  // and, at noise_pct, stray drain ticks mid-frame
  task automatic run_frame(int noise_pct);
    logic [GRAIN_W-1:0] palette [4];
    int                 nids;
    int                 bw;
    int                 bh;
    int                 cols;
    int                 rows;
    cols = lattice_cols();
    rows = lattice_rows();
    nids = $urandom_range(1, 4);
    bw   = $urandom_range(1, 3);
    bh   = $urandom_range(1, 3);
    foreach (palette[i]) palette[i] = GRAIN_W'($urandom);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if ($urandom_range(0, 99) < noise_pct) send_cell(OP_DRAIN, GRAIN_W'($urandom));
        if ($urandom_range(0, 19) == 0) send_cell(OP_CELL, palette[$urandom_range(0, nids - 1)]);
        else send_cell(OP_CELL, palette[((c / bw) + (r / bh)) % nids]);
      end
    end
    finish_frame(noise_pct);
  endtask

  // ---------------------------------------------------------------------------------------
  // 4x3 frame at reset energies: a lone grain in the middle, all-ones ids elsewhere so the
  // far corner stays interior; a stray tick mid-frame and a cell among the drain ticks
  task automatic test_reset_energies();
    logic [GRAIN_W-1:0] ids [12] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    write_reg(REG_COLS, 4);
    write_reg(REG_ROWS, 3);
    for (int i = 0; i < 12; i++) begin
      send_cell(OP_CELL, ids[i]);
      if (i == 1) send_cell(OP_DRAIN, 16'h5A5A);
    end
    send_cell(OP_CELL, 16'h1234);
    repeat (4) send_cell(OP_DRAIN, 16'h0000);
    settle();
  endtask

  // Width and height below range, energies at both ends, and the widest lattice, which is
  // cut short after its first row plus a few cells and then shrunk to close the frame
  task automatic test_register_extremes();
    write_reg(REG_COLS, 0);
    write_reg(REG_ROWS, 0);
    write_reg(REG_BOUNDARY, 0);
    write_reg(REG_INTERIOR, 255);
    run_frame(0);
    settle();
    write_reg(REG_COLS, 1);
    write_reg(REG_ROWS, 1);
    write_reg(REG_BOUNDARY, 255);
    write_reg(REG_INTERIOR, 0);
    run_frame(0);
    settle();
    // 2047 clamps to MAX_COLS
    write_reg(REG_COLS, 2047);
    write_reg(REG_ROWS, 16'hFFFF);
    write_reg(REG_BOUNDARY, $urandom_range(0, 255));
    write_reg(REG_INTERIOR, $urandom_range(0, 255));
    for (int i = 0; i < MAX_COLS + 6; i++) send_cell(OP_CELL, GRAIN_W'((i % MAX_COLS) / 8));
    settle();
    write_reg(REG_ROWS, 2);
    write_reg(REG_COLS, 2);
    finish_frame(0);
    settle();
  endtask

  // Tallest lattice, then shrunk mid-frame below the current position: the next result
  // closes the frame at once
  task automatic test_resize_mid_frame();
    write_reg(REG_COLS, 2);
    write_reg(REG_ROWS, 16'hFFFF);
    repeat (10) send_cell(OP_CELL, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    settle();
    write_reg(REG_ROWS, 2);
    finish_frame(0);
    settle();
  endtask

  // Receiver holds off for a long stretch while a full frame is offered back to back
  task automatic test_output_backpressure();
    allow_idle = 1'b0;
    write_reg(REG_COLS, 6);
    write_reg(REG_ROWS, 5);
    long_hold_req = 1'b1;
    run_frame(0);
    settle();
    allow_idle = 1'b1;
  endtask

  // Random frames of mostly small sizes with fresh registers each time; a few are cut
  // short and shrunk mid-frame. The tail runs without idling.
  task automatic test_random_frames();
    int goal;
    int partial;
    goal = cells_taken + RANDOM_CELLS;
    while (cells_taken < goal) begin
      allow_idle = (goal - cells_taken) > NO_IDLE_TAIL;
      settle();
      if ($urandom_range(0, 19) == 0) write_reg(REG_COLS, $urandom_range(0, 1));
      else if ($urandom_range(0, 3) == 0) write_reg(REG_COLS, $urandom_range(9, 40));
      else write_reg(REG_COLS, $urandom_range(2, 8));
      if ($urandom_range(0, 19) == 0) write_reg(REG_ROWS, $urandom_range(0, 1));
      else write_reg(REG_ROWS, $urandom_range(2, 6));
      write_reg(REG_BOUNDARY, $urandom_range(0, 255));
      write_reg(REG_INTERIOR, $urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) begin
        partial = $urandom_range(1, lattice_cols() * lattice_rows() - 1);
        repeat (partial) send_cell(OP_CELL, GRAIN_W'($urandom));
        settle();
        write_reg(REG_ROWS, $urandom_range(0, 3));
        if ($urandom_range(0, 1)) write_reg(REG_COLS, $urandom_range(0, 6));
        finish_frame(5);
      end else begin
        run_frame(3);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result sink: random stall bursts, plus the long hold when requested (counted here)
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (allow_idle && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: each transaction against the oldest expected energy
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_energies.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = pending_energies.pop_front();
        if (m_tdata[ENERGY_W-1:0] !== want.energy) begin
          errors++;
          $display("%0t: energy mismatch: expected %0d, actual %0d",
                   $time, want.energy, m_tdata[ENERGY_W-1:0]);
        end
        if (m_tdata[ENERGY_W] !== want.on_boundary) begin
          errors++;
          $display("%0t: on_boundary mismatch: expected %b, actual %b",
                   $time, want.on_boundary, m_tdata[ENERGY_W]);
        end
        if (m_tlast !== want.last_of_frame) begin
          errors++;
          $display("%0t: last_of_frame mismatch: expected %b, actual %b",
                   $time, want.last_of_frame, m_tlast);
        end
        if (m_tdata[M_DATA_W-1:ENERGY_W+1] !== '0) begin
          errors++;
          $display("%0t: tdata padding mismatch: expected 0, actual %h",
                   $time, m_tdata[M_DATA_W-1:ENERGY_W+1]);
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_energies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sequence: reset (the unit then clears its line stores), directed tests, random frames
  initial begin
    foreach (upper_ids[i]) upper_ids[i] = '0;
    foreach (middle_ids[i]) middle_ids[i] = '0;
    foreach (window[i]) window[i] = '0;
    arrive_col = 0;
    arrive_row = 0;
    width_reg  = COLS_RST;
    height_reg = ROWS_RST;
    boundary_e = BOUNDARY_RST;
    interior_e = INTERIOR_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_energies();
    test_register_extremes();
    test_resize_mid_frame();
    test_output_backpressure();
    test_random_frames();
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gbei_pkg.sv
rtl/grain_boundary_energy_init_unit.sv
verif/tb_grain_boundary_energy_init_unit.sv
